@@ sv/cdas_pkg.sv @@
// types, constants and month-length helper for the calendar date add/subtract core
// no dependencies; used by every module of the block
package cdas_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned YACC_W  = 15;   // working year, room for carry past the field
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned D_W     = 18;   // signed running day offset
  localparam int unsigned CFG_IDX_W = 1;

  // reciprocal for year / 100, exact for all years below 43690
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QUO_W       = 8;
  localparam int unsigned REM_W       = 7;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1902;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2037;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
  localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

  localparam logic [8:0] LEN_YEAR = 9'd365;

  localparam logic [REM_W-1:0] REM_LAST = 7'd99;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_YEAR = 1'b0,
    REG_MAX_YEAR = 1'b1
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_BAD_MONTH    = 3'd1,
    STAT_BAD_DAY      = 3'd2,
    STAT_BAD_YEAR_IN  = 3'd3,
    STAT_BAD_YEAR_OUT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_CHECK,
    S_LOOP,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    Y_HOLD,
    Y_LOAD,
    Y_DIV,
    Y_REM,
    Y_INC,
    Y_DEC
  } ycmd_t;

  typedef struct packed {
    logic               kind;
    logic [DAY_W-1:0]   day_in;
    logic [MON_W-1:0]   month_in;
    logic [YEAR_W-1:0]  year_in;
    logic [CNT_W-1:0]   day_count;
  } in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day_out;
    logic [MON_W-1:0]   month_out;
    logic [YEAR_W-1:0]  year_out;
    logic [STAT_W-1:0]  status;
  } out_t;

  // leap flags of the working year and its two neighbors
  typedef struct packed {
    logic cur;
    logic nxt;
    logic prv;
  } leap_t;

  typedef struct packed {
    logic                  done;
    logic                  uf;
    logic                  inc;
    logic                  dec;
    logic signed [D_W-1:0] d_nxt;
    logic [MON_W-1:0]      m_nxt;
  } step_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = LEN_31;
    if (m == MON_FEB) begin
      len = leap ? LEN_29 : LEN_28;
    end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
      len = LEN_30;
    end
    return len;
  endfunction

endpackage

@@ sv/cdas_year_unit.sv @@
// working year register with year mod 100 and century mod 4 trackers
// depends on cdas_pkg; gives leap flags for the year and both neighbors
module cdas_year_unit (
  input  logic                          clk,
  input  cdas_pkg::ycmd_t               cmd,
  input  logic [cdas_pkg::YEAR_W-1:0]   year_ld,
  output logic [cdas_pkg::YACC_W-1:0]   year,
  output cdas_pkg::leap_t               leap
);

  logic [cdas_pkg::YACC_W-1:0] y_r, y_nxt;
  logic [cdas_pkg::QUO_W-1:0]  q_r, q_nxt;
  logic [cdas_pkg::REM_W-1:0]  r_r, r_nxt;
  logic [1:0]                  q4_r, q4_nxt;

  logic [cdas_pkg::YEAR_W+cdas_pkg::RECIP_W-1:0] prod;
  logic [cdas_pkg::YACC_W-1:0]                   q100;
  logic [cdas_pkg::YACC_W-1:0]                   rem_full;

  // reciprocal multiply for year / 100
  assign prod = {{cdas_pkg::RECIP_W{1'b0}}, y_r[cdas_pkg::YEAR_W-1:0]}
                * (cdas_pkg::YEAR_W+cdas_pkg::RECIP_W)'(cdas_pkg::RECIP_100);
  assign q100 = {{(cdas_pkg::YACC_W-cdas_pkg::QUO_W){1'b0}}, q_r}
                * cdas_pkg::YACC_W'(100);
  assign rem_full = y_r - q100;

  always_comb begin
    y_nxt  = y_r;
    q_nxt  = q_r;
    r_nxt  = r_r;
    q4_nxt = q4_r;
    unique case (cmd)
      cdas_pkg::Y_HOLD: begin
      end
      cdas_pkg::Y_LOAD: begin
        y_nxt = {1'b0, year_ld};
      end
      cdas_pkg::Y_DIV: begin
        q_nxt = prod[cdas_pkg::RECIP_SHIFT +: cdas_pkg::QUO_W];
      end
      cdas_pkg::Y_REM: begin
        r_nxt  = rem_full[cdas_pkg::REM_W-1:0];
        q4_nxt = q_r[1:0];
      end
      cdas_pkg::Y_INC: begin
        y_nxt = y_r + 1'b1;
        if (r_r == cdas_pkg::REM_LAST) begin
          r_nxt  = '0;
          q4_nxt = q4_r + 1'b1;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
      cdas_pkg::Y_DEC: begin
        y_nxt = y_r - 1'b1;
        if (r_r == '0) begin
          r_nxt  = cdas_pkg::REM_LAST;
          q4_nxt = q4_r - 1'b1;
        end else begin
          r_nxt = r_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    y_r  <= y_nxt;
    q_r  <= q_nxt;
    r_r  <= r_nxt;
    q4_r <= q4_nxt;
  end

  // 4/100/400 rule on the tracked residues
  assign leap.cur = (y_r[1:0] == 2'd0) && ((r_r != '0) || (q4_r == 2'd0));
  assign leap.nxt = (y_r[1:0] == 2'd3) && ((r_r != cdas_pkg::REM_LAST) || (q4_r == 2'd3));
  assign leap.prv = (y_r[1:0] == 2'd1) && ((r_r != 7'd1) || (q4_r == 2'd0));

  assign year = y_r;

endmodule

@@ sv/cdas_step.sv @@
// one carry or borrow step: a whole year when it fits, else one month
// depends on cdas_pkg; purely combinational, driven by the top level sequencer
module cdas_step (
  input  logic                          kind,
  input  logic signed [cdas_pkg::D_W-1:0] d,
  input  logic [cdas_pkg::MON_W-1:0]    m,
  input  logic                          y_zero,
  input  cdas_pkg::leap_t               leap,
  output cdas_pkg::step_t               step
);

  logic [cdas_pkg::DAY_W-1:0]        len_cur;
  logic [cdas_pkg::DAY_W-1:0]        len_prev;
  logic [8:0]                        yl_fwd;
  logic [8:0]                        yl_bwd;
  logic signed [cdas_pkg::D_W-1:0]   s_y;
  logic signed [cdas_pkg::D_W-1:0]   s_m;
  logic [cdas_pkg::MON_W-1:0]        m_dec;

  assign m_dec    = m - 1'b1;
  assign len_cur  = cdas_pkg::month_len(m, leap.cur);
  assign len_prev = (m == cdas_pkg::MON_JAN) ? cdas_pkg::LEN_31
                                             : cdas_pkg::month_len(m_dec, leap.cur);

  // twelve months ahead holds this february when still to come, else next year's
  assign yl_fwd = cdas_pkg::LEN_YEAR
                  + 9'((m <= cdas_pkg::MON_FEB) ? leap.cur : leap.nxt);
  assign yl_bwd = cdas_pkg::LEN_YEAR
                  + 9'((m > cdas_pkg::MON_FEB) ? leap.cur : leap.prv);

  assign s_y = kind ? (d + $signed({{(cdas_pkg::D_W-9){1'b0}}, yl_bwd}))
                    : (d - $signed({{(cdas_pkg::D_W-9){1'b0}}, yl_fwd}));
  assign s_m = kind ? (d + $signed({{(cdas_pkg::D_W-cdas_pkg::DAY_W){1'b0}}, len_prev}))
                    : (d - $signed({{(cdas_pkg::D_W-cdas_pkg::DAY_W){1'b0}}, len_cur}));

  always_comb begin
    step       = '0;
    step.d_nxt = d;
    step.m_nxt = m;
    if (!kind) begin
      priority if (s_y > 0) begin
        step.d_nxt = s_y;
        step.inc   = 1'b1;
      end else if (s_m > 0) begin
        step.d_nxt = s_m;
        if (m == cdas_pkg::MON_DEC) begin
          step.m_nxt = cdas_pkg::MON_JAN;
          step.inc   = 1'b1;
        end else begin
          step.m_nxt = m + 1'b1;
        end
      end else begin
        step.done = 1'b1;
      end
    end else begin
      priority if (d > 0) begin
        step.done = 1'b1;
      end else if (s_y <= 0) begin
        if (y_zero) begin
          step.done = 1'b1;
          step.uf   = 1'b1;
        end else begin
          step.d_nxt = s_y;
          step.dec   = 1'b1;
        end
      end else if (m == cdas_pkg::MON_JAN) begin
        if (y_zero) begin
          step.done = 1'b1;
          step.uf   = 1'b1;
        end else begin
          step.d_nxt = s_m;
          step.m_nxt = cdas_pkg::MON_DEC;
          step.dec   = 1'b1;
        end
      end else begin
        step.d_nxt = s_m;
        step.m_nxt = m_dec;
      end
    end
  end

endmodule

@@ sv/calendar_date_add_subtract_days_core.sv @@
// top level of the gregorian date add/subtract-days core: sequencer, registers, config
// depends on cdas_pkg, cdas_year_unit and cdas_step
//
// An item (date, day count, direction) is taken when start is high and busy is low;
// busy then stays high until the result is out. The result appears on out_data for
// exactly one cycle with out_valid high, and the receiver cannot hold it off. An item
// passes the setup states S_DIV (year / 100 by reciprocal multiply), S_REM (remainder)
// and S_CHECK (date check), then carry or borrow steps in S_LOOP until the loop finds
// the offset inside the month, then S_FINISH to form the result, and then the strobe,
// which overlaps the next accept. Each step moves a whole year when the remaining offset
// covers it and otherwise one month; a bad start date skips the loop. The leap rule
// follows the working year through mod-100 and mod-400 trackers, so the step loop does
// not divide again. The user must write min_year and max_year through the cfg port
// (always ready) only while the block is idle; the block itself does not enforce it.
module calendar_date_add_subtract_days_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  cdas_pkg::in_t                     in_data,
  output logic                              out_valid,
  output cdas_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdas_pkg::YEAR_W-1:0]       cfg_wdata
);

  // config registers
  logic [cdas_pkg::YEAR_W-1:0] min_year_r;
  logic [cdas_pkg::YEAR_W-1:0] max_year_r;

  // sequencer and working registers
  cdas_pkg::state_t               state_r, state_nxt;
  cdas_pkg::in_t                  item_r;
  logic signed [cdas_pkg::D_W-1:0] d_r, d_nxt;
  logic [cdas_pkg::MON_W-1:0]     m_r, m_nxt;
  cdas_pkg::status_t              status_r, status_nxt;
  logic                           uf_r, uf_nxt;
  logic                           out_valid_r;
  cdas_pkg::out_t                 out_data_r, out_data_nxt;

  cdas_pkg::ycmd_t                ycmd;
  logic [cdas_pkg::YACC_W-1:0]    year;
  cdas_pkg::leap_t                leap;
  cdas_pkg::step_t                step;

  logic                           accept;
  logic [cdas_pkg::DAY_W-1:0]     start_len;
  logic signed [cdas_pkg::D_W-1:0] d_start;
  logic                           year_bad_out;

  assign accept    = start && (state_r == cdas_pkg::S_IDLE);
  assign busy      = (state_r != cdas_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  cdas_year_unit u_year (
    .clk     (clk),
    .cmd     (ycmd),
    .year_ld (in_data.year_in),
    .year    (year),
    .leap    (leap)
  );

  cdas_step u_step (
    .kind   (item_r.kind),
    .d      (d_r),
    .m      (m_r),
    .y_zero (year == '0),
    .leap   (leap),
    .step   (step)
  );

  // start-date check uses the leap flag of the loaded year
  assign start_len = cdas_pkg::month_len(item_r.month_in, leap.cur);

  // signed start offset: day plus or minus the count
  assign d_start = item_r.kind
      ? ($signed(cdas_pkg::D_W'(item_r.day_in)) - $signed(cdas_pkg::D_W'(item_r.day_count)))
      : ($signed(cdas_pkg::D_W'(item_r.day_in)) + $signed(cdas_pkg::D_W'(item_r.day_count)));

  // result year: below zero, past the field, or outside the window
  assign year_bad_out = uf_r || year[cdas_pkg::YACC_W-1]
                        || (year[cdas_pkg::YEAR_W-1:0] < min_year_r)
                        || (year[cdas_pkg::YEAR_W-1:0] > max_year_r);

  always_comb begin
    state_nxt    = state_r;
    d_nxt        = d_r;
    m_nxt        = m_r;
    status_nxt   = status_r;
    uf_nxt       = uf_r;
    out_data_nxt = out_data_r;
    ycmd         = cdas_pkg::Y_HOLD;
    unique case (state_r)
      cdas_pkg::S_IDLE: begin
        if (accept) begin
          ycmd      = cdas_pkg::Y_LOAD;
          state_nxt = cdas_pkg::S_DIV;
        end
      end
      cdas_pkg::S_DIV: begin
        ycmd      = cdas_pkg::Y_DIV;
        state_nxt = cdas_pkg::S_REM;
      end
      cdas_pkg::S_REM: begin
        ycmd      = cdas_pkg::Y_REM;
        state_nxt = cdas_pkg::S_CHECK;
      end
      cdas_pkg::S_CHECK: begin
        uf_nxt = 1'b0;
        m_nxt  = item_r.month_in;
        d_nxt  = d_start;
        priority if (item_r.year_in < min_year_r || item_r.year_in > max_year_r) begin
          status_nxt = cdas_pkg::STAT_BAD_YEAR_IN;
          state_nxt  = cdas_pkg::S_FINISH;
        end else if (item_r.month_in < cdas_pkg::MON_JAN
                     || item_r.month_in > cdas_pkg::MON_DEC) begin
          status_nxt = cdas_pkg::STAT_BAD_MONTH;
          state_nxt  = cdas_pkg::S_FINISH;
        end else if (item_r.day_in == '0 || item_r.day_in > start_len) begin
          status_nxt = cdas_pkg::STAT_BAD_DAY;
          state_nxt  = cdas_pkg::S_FINISH;
        end else begin
          status_nxt = cdas_pkg::STAT_OK;
          state_nxt  = cdas_pkg::S_LOOP;
        end
      end
      cdas_pkg::S_LOOP: begin
        if (step.done) begin
          uf_nxt    = step.uf;
          state_nxt = cdas_pkg::S_FINISH;
        end else begin
          d_nxt = step.d_nxt;
          m_nxt = step.m_nxt;
          if (step.inc) begin
            ycmd = cdas_pkg::Y_INC;
          end else if (step.dec) begin
            ycmd = cdas_pkg::Y_DEC;
          end
        end
      end
      cdas_pkg::S_FINISH: begin
        if (status_r == cdas_pkg::STAT_OK && !year_bad_out) begin
          out_data_nxt.day_out   = d_r[cdas_pkg::DAY_W-1:0];
          out_data_nxt.month_out = m_r;
          out_data_nxt.year_out  = year[cdas_pkg::YEAR_W-1:0];
          out_data_nxt.status    = cdas_pkg::STAT_OK;
        end else begin
          // echo the start date on any error
          out_data_nxt.day_out   = item_r.day_in;
          out_data_nxt.month_out = item_r.month_in;
          out_data_nxt.year_out  = item_r.year_in;
          out_data_nxt.status    = (status_r == cdas_pkg::STAT_OK)
                                   ? cdas_pkg::STAT_BAD_YEAR_OUT : status_r;
        end
        state_nxt = cdas_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cdas_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdas_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      min_year_r  <= cdas_pkg::MIN_YEAR_RST;
      max_year_r  <= cdas_pkg::MAX_YEAR_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == cdas_pkg::S_FINISH);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cdas_pkg::REG_MIN_YEAR: min_year_r <= cfg_wdata;
          cdas_pkg::REG_MAX_YEAR: max_year_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    status_r   <= status_nxt;
    uf_r       <= uf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the strobe lasts one cycle: the next item must pass the setup states first
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // an accepted item keeps the block busy through S_DIV and S_REM
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy)
    else $error("block not busy after accept");

  // a good result carries a real month and a nonzero day
  a_ok_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == cdas_pkg::STAT_OK) |->
      (out_data.month_out >= cdas_pkg::MON_JAN && out_data.month_out <= cdas_pkg::MON_DEC
       && out_data.day_out != '0))
    else $error("ok result with impossible date");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= cdas_pkg::STAT_BAD_YEAR_OUT))
    else $error("undefined status code");

endmodule
